FILE: rtl/core/prpp_pkg.sv
package prpp_pkg;

  // Field and datapath widths
  localparam int unsigned POS_W  = 32;
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned CRD_W  = 36;
  localparam int unsigned Z_W    = 20;
  localparam int unsigned TRIG_W = 18;
  localparam int unsigned DIVR_W = 40;
  localparam int unsigned DIVD_W = 32;

  // Angles in units of 2^-16 rad; the yaw limits are in units of 2^-13 rad
  localparam logic signed [Z_W-1:0] PI_Q16      = 20'sd205887;
  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [Z_W-1:0] YAW_LIM_POS = 20'sd25736;
  localparam logic signed [Z_W-1:0] YAW_LIM_NEG = -20'sd25736;

  localparam logic signed [CRD_W-1:0] VEC_ONE     = 36'sd268435456;
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 36'sd9949;

  localparam logic [31:0]      SPACING_MIN = 32'd3277;
  localparam logic [31:0]      SPACING_DEF = 32'd6554;
  localparam logic [31:0]      SPACING_SAT = 32'hFFFF_FFFF;
  localparam logic [SPD_W-1:0] SPEED_MIN   = 16'd128;

  // Configuration registers
  localparam int unsigned      CFG_IDX_W   = 2;
  localparam int unsigned      CFG_DATA_W  = 16;
  localparam logic [1:0]       REG_HORIZON = 2'd0;
  localparam logic [1:0]       REG_TARGET  = 2'd1;
  localparam logic [15:0]      HORIZON_RST = 16'd384;
  localparam logic [15:0]      TARGET_RST  = 16'd640;

  typedef struct packed {
    logic                    req_type;
    logic                    first_point;
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic signed [15:0]      point_qz;
    logic signed [15:0]      point_qw;
    logic signed [POS_W-1:0] veh_x;
    logic signed [POS_W-1:0] veh_y;
    logic signed [ANG_W-1:0] veh_yaw;
    logic [SPD_W-1:0]        veh_speed;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ref_x;
    logic signed [POS_W-1:0] ref_y;
    logic signed [ANG_W-1:0] ref_yaw;
    logic [SPD_W-1:0]        ref_speed;
    logic [3:0]              ref_slot;
    logic                    last_ref;
    logic                    path_empty;
    logic                    path_overflow;
  } res_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_RESTART,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    kind_t kind;
    req_t  item;
  } job_t;

  typedef struct packed {
    logic [15:0] horizon_time;
    logic [15:0] target_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [ANG_W-1:0] yaw;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIVD_W-1:0] quotient;
    logic [DIVR_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_INIT,
    ST_CORDIC,
    ST_LOAD_WRITE,
    ST_SPC_DIFF,
    ST_SPC_MUL,
    ST_SPC_SUM,
    ST_SPC_SQRT,
    ST_SPC_DONE,
    ST_ROT_INIT,
    ST_ROT_DONE,
    ST_SCAN,
    ST_STRIDE_MUL,
    ST_STRIDE_GO,
    ST_STRIDE_DIV,
    ST_MOD_GO,
    ST_MOD_DIV,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_EMPTY_OUT
  } state_t;

  typedef enum logic {
    MODE_VECTOR,
    MODE_ROTATE
  } cmode_t;

  // Arctangent of 2^-i, units of 2^-16 rad, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_at(input logic [3:0] i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      4'd0:    a = 20'sd51472;
      4'd1:    a = 20'sd30385;
      4'd2:    a = 20'sd16055;
      4'd3:    a = 20'sd8150;
      4'd4:    a = 20'sd4091;
      4'd5:    a = 20'sd2047;
      4'd6:    a = 20'sd1024;
      4'd7:    a = 20'sd512;
      4'd8:    a = 20'sd256;
      4'd9:    a = 20'sd128;
      4'd10:   a = 20'sd64;
      4'd11:   a = 20'sd32;
      4'd12:   a = 20'sd16;
      4'd13:   a = 20'sd8;
      4'd14:   a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/prpp_ram.sv
module prpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/prpp_front.sv
module prpp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  prpp_pkg::req_t      req,
  output logic                head_valid,
  output prpp_pkg::job_t      head,
  input  logic                take
);

  prpp_pkg::job_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     used;
  logic           wr;
  logic           rd;
  prpp_pkg::job_t incoming;

  // Classify the incoming item
  always_comb begin
    incoming.item = req;
    if (req.req_type) begin
      incoming.kind = prpp_pkg::KIND_QUERY;
    end else if (req.first_point) begin
      incoming.kind = prpp_pkg::KIND_RESTART;
    end else begin
      incoming.kind = prpp_pkg::KIND_LOAD;
    end
  end

  assign full       = (used == 2'd2);
  assign head_valid = (used != 2'd0);
  assign head       = slots[rd_ptr];
  assign wr         = push && !full;
  assign rd         = take && head_valid;

  // Hold classified items until the back end takes them
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      used <= used + 2'(wr) - 2'(rd);
    end
  end

endmodule

FILE: rtl/core/prpp_div.sv
module prpp_div (
  input  logic               clk,
  input  logic               rst,
  input  prpp_pkg::div_req_t req,
  output prpp_pkg::div_rsp_t rsp
);

  localparam int unsigned K_W = $clog2(prpp_pkg::DIVD_W);

  logic                          busy;
  logic [K_W-1:0]                k;
  logic [prpp_pkg::DIVD_W-1:0]   quo;
  logic [prpp_pkg::DIVR_W-1:0]   rem;
  logic [prpp_pkg::DIVR_W-1:0]   dvs;
  logic [prpp_pkg::DIVR_W:0]     trial;

  assign trial = {rem, quo[prpp_pkg::DIVD_W-1]};

  assign rsp.busy      = busy;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
      k   <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= prpp_pkg::DIVR_W'(trial - {1'b0, dvs});
        quo <= {quo[prpp_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem <= prpp_pkg::DIVR_W'(trial);
        quo <= {quo[prpp_pkg::DIVD_W-2:0], 1'b0};
      end
      k <= k + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (busy && k == K_W'(prpp_pkg::DIVD_W - 1)) begin
      busy <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/prpp_back.sv
module prpp_back #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned NUM_REFS   = 15
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  prpp_pkg::job_t job,
  output logic           take,
  input  prpp_pkg::cfg_t cfg,
  output logic           res_valid,
  output prpp_pkg::res_t res,
  input  logic           pop
);

  localparam int unsigned AW      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int unsigned SLOT_W  = $clog2(NUM_REFS + 1);
  localparam int unsigned ENTRY_W = $bits(prpp_pkg::entry_t);
  localparam int unsigned CRD_W   = prpp_pkg::CRD_W;
  localparam int unsigned Z_W     = prpp_pkg::Z_W;
  localparam int unsigned TRIG_W  = prpp_pkg::TRIG_W;
  localparam int unsigned D_W     = 67;

  prpp_pkg::state_t state, state_next;

  // Control strobes
  logic               ram_we;
  logic               res_load;
  logic               slot_free;
  prpp_pkg::div_req_t div_req;
  prpp_pkg::div_rsp_t div_rsp;

  // Path state
  prpp_pkg::req_t          cur;
  logic [CNT_W-1:0]        count;
  logic                    overflow;
  logic [31:0]             spacing;
  logic signed [31:0]      p0x;
  logic signed [31:0]      p0y;
  logic [CNT_W-1:0]        slot;

  // Shared CORDIC
  logic signed [CRD_W-1:0] cx, cy;
  logic signed [Z_W-1:0]   cz;
  prpp_pkg::cmode_t        mode;
  logic [3:0]              iter;
  logic                    vzero;
  logic                    neg;
  logic signed [31:0]      mul_a, mul_b;
  logic signed [TRIG_W-1:0] cosv, sinv;

  // Spacing square root
  logic [32:0]             ax, ay;
  logic [64:0]             sqx, sqy;
  logic [63:0]             sq_v, sq_res;
  logic [4:0]              sq_k;

  // Scan pipeline
  logic [CNT_W-1:0]        scan_i;
  logic                    iss;
  logic                    rv, v1, v2, v3;
  logic [AW-1:0]           ri, i1, i2, i3;
  logic signed [32:0]      dx1, dy1;
  logic [64:0]             sqx2, sqy2;
  logic signed [50:0]      px2, py2;
  logic [65:0]             d3;
  logic                    behind3;
  logic [D_W-1:0]          best;
  logic [AW-1:0]           closest;

  // Stride and emission
  logic [31:0]             look;
  logic [prpp_pkg::DIVR_W-1:0] den;
  logic [31:0]             stride;
  logic [CNT_W-1:0]        stride_m;
  logic [CNT_W-1:0]        idx;
  logic [SLOT_W-1:0]       eslot;

  // Memory port
  logic [AW-1:0]           raddr;
  logic [ENTRY_W-1:0]      rdata_raw;
  prpp_pkg::entry_t        rd_e;
  prpp_pkg::entry_t        wr_e;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  prpp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot[AW-1:0]),
    .wdata(wr_e),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  prpp_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign rd_e      = prpp_pkg::entry_t'(rdata_raw);
  assign raddr     = (state == prpp_pkg::ST_SCAN) ? scan_i[AW-1:0] : idx[AW-1:0];
  assign slot_free = !res_valid || pop;
  assign iss       = (state == prpp_pkg::ST_SCAN) && (scan_i < count);

  // CORDIC step, heading rounding and stage-4 distance
  logic signed [CRD_W-1:0] sh_x, sh_y, cx_step, cy_step;
  logic signed [Z_W-1:0]   cz_step;
  logic                    dir;
  logic [Z_W-1:0]          z_mag, z_rnd;
  logic signed [Z_W-1:0]   z_q;
  logic signed [prpp_pkg::ANG_W-1:0] yaw_calc;
  logic [D_W-1:0]          dt;
  logic signed [51:0]      dot2;

  always_comb begin
    sh_x = cx >>> iter;
    sh_y = cy >>> iter;
    if (mode == prpp_pkg::MODE_ROTATE) begin
      dir = !cz[Z_W-1];
    end else begin
      dir = cy[CRD_W-1] || (cy == '0);
    end
    if (dir) begin
      cx_step = cx - sh_y;
      cy_step = cy + sh_x;
      cz_step = cz - prpp_pkg::atan_at(iter);
    end else begin
      cx_step = cx + sh_y;
      cy_step = cy - sh_x;
      cz_step = cz + prpp_pkg::atan_at(iter);
    end

    z_mag = cz[Z_W-1] ? Z_W'(-cz) : Z_W'(cz);
    z_rnd = (z_mag + Z_W'(4)) >> 3;
    z_q   = cz[Z_W-1] ? -signed'(z_rnd) : signed'(z_rnd);
    if (vzero) begin
      yaw_calc = '0;
    end else if (z_q > prpp_pkg::YAW_LIM_POS) begin
      yaw_calc = prpp_pkg::ANG_W'(prpp_pkg::YAW_LIM_POS);
    end else if (z_q < prpp_pkg::YAW_LIM_NEG) begin
      yaw_calc = prpp_pkg::ANG_W'(prpp_pkg::YAW_LIM_NEG);
    end else begin
      yaw_calc = prpp_pkg::ANG_W'(z_q);
    end

    dt   = behind3 ? (D_W'(d3) + {d3, 1'b0}) : D_W'(d3);
    dot2 = 52'(px2) + 52'(py2);

    wr_e.x   = cur.point_x;
    wr_e.y   = cur.point_y;
    wr_e.yaw = yaw_calc;
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    take       = 1'b0;
    ram_we     = 1'b0;
    res_load   = 1'b0;
    div_req    = '0;
    unique case (state)
      prpp_pkg::ST_IDLE: begin
        if (job_valid) begin
          take = 1'b1;
          unique case (job.kind)
            prpp_pkg::KIND_LOAD: begin
              if (count != CNT_W'(MAX_POINTS)) begin
                state_next = prpp_pkg::ST_LOAD_MUL;
              end
            end
            prpp_pkg::KIND_RESTART: state_next = prpp_pkg::ST_LOAD_MUL;
            prpp_pkg::KIND_QUERY: begin
              state_next = (count == '0) ? prpp_pkg::ST_EMPTY_OUT : prpp_pkg::ST_ROT_INIT;
            end
            default: ;
          endcase
        end
      end
      prpp_pkg::ST_LOAD_MUL:  state_next = prpp_pkg::ST_LOAD_INIT;
      prpp_pkg::ST_LOAD_INIT: state_next = prpp_pkg::ST_CORDIC;
      prpp_pkg::ST_CORDIC: begin
        if (iter == 4'd15) begin
          state_next = (mode == prpp_pkg::MODE_VECTOR) ? prpp_pkg::ST_LOAD_WRITE
                                                      : prpp_pkg::ST_ROT_DONE;
        end
      end
      prpp_pkg::ST_LOAD_WRITE: begin
        ram_we     = 1'b1;
        state_next = (slot == CNT_W'(1)) ? prpp_pkg::ST_SPC_DIFF : prpp_pkg::ST_IDLE;
      end
      prpp_pkg::ST_SPC_DIFF: state_next = prpp_pkg::ST_SPC_MUL;
      prpp_pkg::ST_SPC_MUL:  state_next = prpp_pkg::ST_SPC_SUM;
      prpp_pkg::ST_SPC_SUM: begin
        state_next = ((66'(sqx) + 66'(sqy)) >> 64 != 66'd0) ? prpp_pkg::ST_IDLE
                                                           : prpp_pkg::ST_SPC_SQRT;
      end
      prpp_pkg::ST_SPC_SQRT: begin
        if (sq_k == 5'd31) begin
          state_next = prpp_pkg::ST_SPC_DONE;
        end
      end
      prpp_pkg::ST_SPC_DONE: state_next = prpp_pkg::ST_IDLE;
      prpp_pkg::ST_ROT_INIT: state_next = prpp_pkg::ST_CORDIC;
      prpp_pkg::ST_ROT_DONE: state_next = prpp_pkg::ST_SCAN;
      prpp_pkg::ST_SCAN: begin
        if (scan_i == count && !rv && !v1 && !v2 && !v3) begin
          state_next = prpp_pkg::ST_STRIDE_MUL;
        end
      end
      prpp_pkg::ST_STRIDE_MUL: state_next = prpp_pkg::ST_STRIDE_GO;
      prpp_pkg::ST_STRIDE_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = look;
        div_req.divisor  = den;
        state_next       = prpp_pkg::ST_STRIDE_DIV;
      end
      prpp_pkg::ST_STRIDE_DIV: begin
        if (!div_rsp.busy) begin
          state_next = prpp_pkg::ST_MOD_GO;
        end
      end
      prpp_pkg::ST_MOD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = stride;
        div_req.divisor  = prpp_pkg::DIVR_W'(count);
        state_next       = prpp_pkg::ST_MOD_DIV;
      end
      prpp_pkg::ST_MOD_DIV: begin
        if (!div_rsp.busy) begin
          state_next = prpp_pkg::ST_EMIT_RD;
        end
      end
      prpp_pkg::ST_EMIT_RD: state_next = prpp_pkg::ST_EMIT_OUT;
      prpp_pkg::ST_EMIT_OUT: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = (eslot == SLOT_W'(NUM_REFS - 1)) ? prpp_pkg::ST_IDLE
                                                        : prpp_pkg::ST_EMIT_RD;
        end
      end
      prpp_pkg::ST_EMPTY_OUT: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = prpp_pkg::ST_IDLE;
        end
      end
      default: state_next = prpp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prpp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Path control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      spacing  <= prpp_pkg::SPACING_DEF;
    end else begin
      if (take) begin
        unique case (job.kind)
          prpp_pkg::KIND_LOAD: begin
            if (count == CNT_W'(MAX_POINTS)) begin
              overflow <= 1'b1;
            end
          end
          prpp_pkg::KIND_RESTART: begin
            count    <= '0;
            overflow <= 1'b0;
            spacing  <= prpp_pkg::SPACING_DEF;
          end
          default: ;
        endcase
      end
      if (state == prpp_pkg::ST_LOAD_WRITE) begin
        count <= slot + CNT_W'(1);
      end
      if (state == prpp_pkg::ST_SPC_SUM && state_next == prpp_pkg::ST_IDLE) begin
        spacing <= prpp_pkg::SPACING_SAT;
      end
      if (state == prpp_pkg::ST_SPC_DONE) begin
        spacing <= (sq_res[31:0] < prpp_pkg::SPACING_MIN) ? prpp_pkg::SPACING_MIN
                                                          : sq_res[31:0];
      end
    end
  end

  // Datapath for loads, CORDIC, spacing, stride and emission
  logic signed [CRD_W-1:0] vx0, vy0;
  logic signed [Z_W-1:0]   zy;
  logic [64:0]             bitv;
  logic [64:0]             sq_t;
  logic [CNT_W:0]          nsum;

  always_comb begin
    vx0  = prpp_pkg::VEC_ONE - (CRD_W'(mul_b) <<< 1);
    vy0  = CRD_W'(mul_a) <<< 1;
    zy   = {cur.veh_yaw[prpp_pkg::ANG_W-1], cur.veh_yaw, 3'b000};
    bitv = 65'h0_4000_0000_0000_0000 >> {sq_k, 1'b0};
    sq_t = 65'(sq_res) + bitv;
    nsum = {1'b0, idx} + {1'b0, stride_m};
  end

  always_ff @(posedge clk) begin
    unique case (state)
      prpp_pkg::ST_IDLE: begin
        if (take) begin
          cur  <= job.item;
          slot <= (job.kind == prpp_pkg::KIND_RESTART) ? '0 : count;
        end
      end
      prpp_pkg::ST_LOAD_MUL: begin
        mul_a <= 32'(cur.point_qw) * 32'(cur.point_qz);
        mul_b <= 32'(cur.point_qz) * 32'(cur.point_qz);
      end
      prpp_pkg::ST_LOAD_INIT: begin
        vzero <= (vx0 == '0) && (vy0 == '0);
        mode  <= prpp_pkg::MODE_VECTOR;
        iter  <= '0;
        if (vx0[CRD_W-1]) begin
          cz <= vy0[CRD_W-1] ? -prpp_pkg::PI_Q16 : prpp_pkg::PI_Q16;
          cx <= -vx0;
          cy <= -vy0;
        end else begin
          cz <= '0;
          cx <= vx0;
          cy <= vy0;
        end
      end
      prpp_pkg::ST_CORDIC: begin
        cx   <= cx_step;
        cy   <= cy_step;
        cz   <= cz_step;
        iter <= iter + 4'd1;
      end
      prpp_pkg::ST_LOAD_WRITE: begin
        if (slot == '0) begin
          p0x <= cur.point_x;
          p0y <= cur.point_y;
        end
      end
      prpp_pkg::ST_SPC_DIFF: begin
        ax <= mag33(33'(cur.point_x) - 33'(p0x));
        ay <= mag33(33'(cur.point_y) - 33'(p0y));
      end
      prpp_pkg::ST_SPC_MUL: begin
        sqx <= 65'(ax) * 65'(ax);
        sqy <= 65'(ay) * 65'(ay);
      end
      prpp_pkg::ST_SPC_SUM: begin
        sq_v   <= 64'(sqx + sqy);
        sq_res <= '0;
        sq_k   <= '0;
      end
      prpp_pkg::ST_SPC_SQRT: begin
        if (65'(sq_v) >= sq_t) begin
          sq_v   <= 64'(65'(sq_v) - sq_t);
          sq_res <= 64'((sq_res >> 1) + 64'(bitv));
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_k <= sq_k + 5'd1;
      end
      prpp_pkg::ST_ROT_INIT: begin
        cx    <= prpp_pkg::CORDIC_GAIN;
        cy    <= '0;
        mode  <= prpp_pkg::MODE_ROTATE;
        iter  <= '0;
        if (zy > prpp_pkg::HALF_PI_Q16) begin
          cz  <= zy - prpp_pkg::PI_Q16;
          neg <= 1'b1;
        end else if (zy < -prpp_pkg::HALF_PI_Q16) begin
          cz  <= zy + prpp_pkg::PI_Q16;
          neg <= 1'b1;
        end else begin
          cz  <= zy;
          neg <= 1'b0;
        end
      end
      prpp_pkg::ST_ROT_DONE: begin
        cosv <= neg ? TRIG_W'(-cx) : TRIG_W'(cx);
        sinv <= neg ? TRIG_W'(-cy) : TRIG_W'(cy);
      end
      prpp_pkg::ST_STRIDE_MUL: begin
        look <= 32'((cur.veh_speed < prpp_pkg::SPEED_MIN) ? prpp_pkg::SPEED_MIN
                                                          : cur.veh_speed)
                * 32'(cfg.horizon_time);
        den  <= prpp_pkg::DIVR_W'(spacing) * prpp_pkg::DIVR_W'(NUM_REFS);
      end
      prpp_pkg::ST_STRIDE_DIV: begin
        if (!div_rsp.busy) begin
          stride <= (div_rsp.quotient == '0) ? 32'd1 : div_rsp.quotient;
        end
      end
      prpp_pkg::ST_MOD_DIV: begin
        if (!div_rsp.busy) begin
          stride_m <= CNT_W'(div_rsp.remainder);
          idx      <= CNT_W'(closest);
          eslot    <= '0;
        end
      end
      prpp_pkg::ST_EMIT_OUT: begin
        if (slot_free) begin
          eslot <= eslot + SLOT_W'(1);
          idx   <= (nsum >= {1'b0, count}) ? CNT_W'(nsum - {1'b0, count}) : CNT_W'(nsum);
        end
      end
      default: ;
    endcase
  end

  // Scan: issue one read per cycle, four stages to the running minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      rv <= iss;
      v1 <= rv;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (state == prpp_pkg::ST_ROT_DONE) begin
      scan_i <= '0;
    end else if (iss) begin
      scan_i <= scan_i + CNT_W'(1);
    end
    ri      <= scan_i[AW-1:0];
    i1      <= ri;
    i2      <= i1;
    i3      <= i2;
    dx1     <= 33'(rd_e.x) - 33'(cur.veh_x);
    dy1     <= 33'(rd_e.y) - 33'(cur.veh_y);
    sqx2    <= 65'(mag33(dx1)) * 65'(mag33(dx1));
    sqy2    <= 65'(mag33(dy1)) * 65'(mag33(dy1));
    px2     <= 51'(dx1) * 51'(cosv);
    py2     <= 51'(dy1) * 51'(sinv);
    d3      <= 66'(sqx2) + 66'(sqy2);
    behind3 <= dot2[51];
    if (v3 && (i3 == '0 || dt < best)) begin
      best    <= dt;
      closest <= i3;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      if (state == prpp_pkg::ST_EMPTY_OUT) begin
        res.ref_x         <= '0;
        res.ref_y         <= '0;
        res.ref_yaw       <= '0;
        res.ref_speed     <= '0;
        res.ref_slot      <= '0;
        res.last_ref      <= 1'b1;
        res.path_empty    <= 1'b1;
        res.path_overflow <= overflow;
      end else begin
        res.ref_x         <= rd_e.x;
        res.ref_y         <= rd_e.y;
        res.ref_yaw       <= rd_e.yaw;
        res.ref_speed     <= cfg.target_speed;
        res.ref_slot      <= 4'(eslot);
        res.last_ref      <= (eslot == SLOT_W'(NUM_REFS - 1));
        res.path_empty    <= 1'b0;
        res.path_overflow <= overflow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/path_reference_point_picker_core.sv
// Path reference point picker. Load items fill a path store of MAX_POINTS
// entries (x, y and a heading taken from the quaternion by a 16-step CORDIC);
// a query scans every stored point through one memory read port, picks the
// nearest one (distance tripled behind the vehicle) and emits NUM_REFS points
// spaced by a speed- and horizon-dependent stride. A load that stores the
// second point also takes the square root of the spacing, one bit per cycle.
// In a query the scan reads one point per cycle, then two divisions set the
// stride and its remainder modulo the point count. An empty path answers
// with a single result flagged path_empty. Items queue two deep at the
// input and one result waits in the output register, so either side may
// stall without losing items. No clearing pass is needed after reset;
// configuration writes take effect at once.
module path_reference_point_picker_core #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned NUM_REFS   = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  prpp_pkg::req_t                     req,
  output logic                               empty,
  input  logic                               pop,
  output prpp_pkg::res_t                     res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [prpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic           head_valid;
  prpp_pkg::job_t head;
  logic           take;
  logic           res_valid;
  prpp_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.horizon_time <= prpp_pkg::HORIZON_RST;
      cfg.target_speed <= prpp_pkg::TARGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prpp_pkg::REG_HORIZON: cfg.horizon_time <= cfg_data;
        prpp_pkg::REG_TARGET:  cfg.target_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  prpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .head_valid(head_valid),
    .head      (head),
    .take      (take)
  );

  prpp_back #(
    .MAX_POINTS(MAX_POINTS),
    .NUM_REFS  (NUM_REFS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(head_valid),
    .job      (head),
    .take     (take),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res),
    .pop      (pop)
  );

endmodule
